[hdl/frb_pkg.sv]
// ----------------------------------------------------------------------------
// frb_pkg
// Shared types and constants for the length-prefixed frame ring buffer:
// field widths, item mode codes, result status codes and controller states.
// ----------------------------------------------------------------------------
package frb_pkg;

   // Default sizes of the ring and of the longest frame.
   localparam int DEF_BUFFER_BYTES = 1024;
   localparam int DEF_MAX_FRAME    = 256;

   // Every frame is stored behind a two-byte little-endian length prefix.
   localparam int PREFIX_BYTES = 2;

   // Fixed widths of the item and result fields.
   localparam int MODE_W    = 3;
   localparam int LEN_W     = 9;
   localparam int BYTE_W    = 8;
   localparam int STAT_W    = 2;
   localparam int DROP_W    = 32;
   localparam int USED_W    = 11;
   localparam int PFX_W     = 16;
   localparam int PFX_SUM_W = PFX_W + 1;

   // Item modes.
   localparam logic [MODE_W-1:0] MODE_BEGIN = 3'd0;
   localparam logic [MODE_W-1:0] MODE_PUSH  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_READ  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_POP   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_TAKE  = 3'd4;

   // Result status codes.
   localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
   localparam logic [STAT_W-1:0] STAT_BAD_LEN = 2'd1;
   localparam logic [STAT_W-1:0] STAT_EMPTY   = 2'd2;
   localparam logic [STAT_W-1:0] STAT_BUSY    = 2'd3;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_FIT,
      S_PFX_WR,
      S_PFX_LO,
      S_PFX_HI,
      S_DATA
   } frb_state_type;

endpackage

[hdl/frame_ring_buffer_drop_oldest.sv]
// ----------------------------------------------------------------------------
// frame_ring_buffer_drop_oldest
// A result is strobed in the cycle after the last busy cycle. Push byte, take,
// rejects, bad lengths and empty reads or pops end in S_EXEC; pop and read
// fetch the head prefix in S_PFX_LO and S_PFX_HI from the single read port,
// and read adds S_DATA to fetch the byte; begin push passes S_FIT and S_PFX_WR,
// with another S_FIT, mostly with both prefix reads, per dropped frame. Reset
// clears pointers and counters, not the ring contents. Results cannot be held off.
// ----------------------------------------------------------------------------
module frame_ring_buffer_drop_oldest #(
   parameter int BUFFER_BYTES = frb_pkg::DEF_BUFFER_BYTES,
   parameter int MAX_FRAME    = frb_pkg::DEF_MAX_FRAME
) (
   input  logic                        clock,
   input  logic                        reset,
   // Request channel: a beat is taken when start is high and busy is low.
   input  logic                        start,
   output logic                        busy,
   input  logic [frb_pkg::MODE_W-1:0]  req_mode,
   input  logic [frb_pkg::LEN_W-1:0]   req_frame_len,
   input  logic [frb_pkg::BYTE_W-1:0]  req_data_byte,
   input  logic [frb_pkg::LEN_W-1:0]   req_read_limit,
   input  logic [frb_pkg::BYTE_W-1:0]  req_byte_offset,
   // Response channel: one beat per request, shown for one cycle.
   output logic                        rsp_valid,
   output logic [frb_pkg::STAT_W-1:0]  rsp_status,
   output logic [frb_pkg::LEN_W-1:0]   rsp_head_len,
   output logic [frb_pkg::BYTE_W-1:0]  rsp_read_byte,
   output logic [frb_pkg::DROP_W-1:0]  rsp_drop_total,
   output logic [frb_pkg::USED_W-1:0]  rsp_used_bytes
);

   // Ring address width, width of the used-byte count, and a width that holds
   // the sum of two counts without overflow.
   localparam int AW = $clog2(BUFFER_BYTES);
   localparam int CW = $clog2(BUFFER_BYTES + 1);
   localparam int SW = CW + 1;

   // Wraps a sum of a ring address and an offset of at most one ring length.
   function automatic logic [AW-1:0] wrap(input logic [AW:0] sum);
      logic [AW:0] lim;
      lim = (AW + 1)'(BUFFER_BYTES);
      if (sum >= lim) begin
         return AW'(sum - lim);
      end
      return AW'(sum);
   endfunction

   // Controller state and the request captured at acceptance.
   frb_pkg::frb_state_type state_ff, state_in;
   logic [frb_pkg::MODE_W-1:0] mode_ff, mode_in;
   logic [frb_pkg::LEN_W-1:0]  flen_ff, flen_in;
   logic [frb_pkg::BYTE_W-1:0] data_ff, data_in;
   logic [frb_pkg::LEN_W-1:0]  limit_ff, limit_in;
   logic [frb_pkg::BYTE_W-1:0] offset_ff, offset_in;

   // Queue bookkeeping.
   logic [AW-1:0]              wp_ff, wp_in;
   logic [AW-1:0]              rp_ff, rp_in;
   logic [CW-1:0]              used_ff, used_in;
   logic [frb_pkg::DROP_W-1:0] drop_ff, drop_in;
   logic [frb_pkg::LEN_W-1:0]  open_rem_ff, open_rem_in;
   logic [frb_pkg::LEN_W-1:0]  open_tot_ff, open_tot_in;

   // Low prefix byte of the head frame, and its length while a byte read runs.
   logic [frb_pkg::BYTE_W-1:0] pfx_lo_ff, pfx_lo_in;
   logic [frb_pkg::LEN_W-1:0]  hlen_ff, hlen_in;

   // Response registers.
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [frb_pkg::STAT_W-1:0] rsp_status_ff, rsp_status_in;
   logic [frb_pkg::LEN_W-1:0]  rsp_head_len_ff, rsp_head_len_in;
   logic [frb_pkg::BYTE_W-1:0] rsp_read_byte_ff, rsp_read_byte_in;
   logic [frb_pkg::DROP_W-1:0] rsp_drop_ff, rsp_drop_in;
   logic [frb_pkg::USED_W-1:0] rsp_used_ff, rsp_used_in;

   // Ring port.
   logic                       mem_we;
   logic [AW-1:0]              mem_waddr;
   logic [frb_pkg::BYTE_W-1:0] mem_wdata;
   logic [AW-1:0]              mem_raddr;
   logic [frb_pkg::BYTE_W-1:0] mem_rdata;

   // Head frame decode, valid in S_PFX_HI when the high prefix byte arrives.
   logic [frb_pkg::PFX_W-1:0]     head_pfx;
   logic [frb_pkg::PFX_SUM_W-1:0] head_tot;
   logic                          head_ok;
   logic [frb_pkg::PFX_W-1:0]     sat_limit;
   logic                          used_short;
   logic                          bad_len;
   logic                          fits;
   logic [frb_pkg::LEN_W:0]       push_pos;
   logic [frb_pkg::LEN_W:0]       open_span;

   frb_ram #(
      .DEPTH (BUFFER_BYTES),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign head_pfx = {mem_rdata, pfx_lo_ff};
   assign head_tot = frb_pkg::PFX_SUM_W'(head_pfx)
                   + frb_pkg::PFX_SUM_W'(frb_pkg::PREFIX_BYTES);
   // A head frame is consistent only when its prefix fits inside the used bytes.
   assign head_ok  = head_tot <= frb_pkg::PFX_SUM_W'(used_ff);

   // The reader's limit saturates at the longest legal frame.
   assign sat_limit = (32'(limit_ff) > MAX_FRAME) ? frb_pkg::PFX_W'(MAX_FRAME)
                                                  : frb_pkg::PFX_W'(limit_ff);

   assign used_short = used_ff < CW'(frb_pkg::PREFIX_BYTES);

   assign bad_len = (flen_ff == '0) || (32'(flen_ff) > MAX_FRAME)
                 || (32'(flen_ff) + frb_pkg::PREFIX_BYTES > BUFFER_BYTES);

   // Only evaluated after the length check passed, so the frame fits in SW bits.
   assign fits = SW'(used_ff) + SW'(flen_ff) + SW'(frb_pkg::PREFIX_BYTES)
              <= SW'(BUFFER_BYTES);

   // Ring offset of the next frame byte, and the full span of the open frame.
   assign push_pos  = (frb_pkg::LEN_W + 1)'(frb_pkg::PREFIX_BYTES)
                    + (frb_pkg::LEN_W + 1)'(open_tot_ff - open_rem_ff);
   assign open_span = (frb_pkg::LEN_W + 1)'(frb_pkg::PREFIX_BYTES)
                    + (frb_pkg::LEN_W + 1)'(open_tot_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= frb_pkg::S_IDLE;
         wp_ff        <= '0;
         rp_ff        <= '0;
         used_ff      <= '0;
         drop_ff      <= '0;
         open_rem_ff  <= '0;
         open_tot_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         used_ff      <= used_in;
         drop_ff      <= drop_in;
         open_rem_ff  <= open_rem_in;
         open_tot_ff  <= open_tot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff          <= mode_in;
      flen_ff          <= flen_in;
      data_ff          <= data_in;
      limit_ff         <= limit_in;
      offset_ff        <= offset_in;
      pfx_lo_ff        <= pfx_lo_in;
      hlen_ff          <= hlen_in;
      rsp_status_ff    <= rsp_status_in;
      rsp_head_len_ff  <= rsp_head_len_in;
      rsp_read_byte_ff <= rsp_read_byte_in;
      rsp_drop_ff      <= rsp_drop_in;
      rsp_used_ff      <= rsp_used_in;
   end

   always_comb begin
      state_in    = state_ff;
      mode_in     = mode_ff;
      flen_in     = flen_ff;
      data_in     = data_ff;
      limit_in    = limit_ff;
      offset_in   = offset_ff;
      wp_in       = wp_ff;
      rp_in       = rp_ff;
      used_in     = used_ff;
      drop_in     = drop_ff;
      open_rem_in = open_rem_ff;
      open_tot_in = open_tot_ff;
      pfx_lo_in   = pfx_lo_ff;
      hlen_in     = hlen_ff;

      mem_we    = 1'b0;
      mem_waddr = wp_ff;
      mem_wdata = data_ff;
      mem_raddr = rp_ff;

      // The response payload is only looked at while the strobe is high, so it
      // simply defaults to an empty ok beat every cycle.
      rsp_valid_in     = 1'b0;
      rsp_status_in    = frb_pkg::STAT_OK;
      rsp_head_len_in  = '0;
      rsp_read_byte_in = '0;
      rsp_drop_in      = '0;

      unique case (state_ff)
         frb_pkg::S_IDLE: begin
            if (start) begin
               mode_in   = req_mode;
               flen_in   = req_frame_len;
               data_in   = req_data_byte;
               limit_in  = req_read_limit;
               offset_in = req_byte_offset;
               state_in  = frb_pkg::S_EXEC;
            end
         end

         frb_pkg::S_EXEC: begin
            priority if (mode_ff == frb_pkg::MODE_PUSH) begin
               state_in     = frb_pkg::S_IDLE;
               rsp_valid_in = 1'b1;
               if (open_rem_ff == '0) begin
                  rsp_status_in = frb_pkg::STAT_BUSY;
               end else begin
                  // Store the byte; the last one commits the whole frame.
                  mem_we      = 1'b1;
                  mem_waddr   = wrap((AW + 1)'(wp_ff) + (AW + 1)'(push_pos));
                  mem_wdata   = data_ff;
                  open_rem_in = open_rem_ff - frb_pkg::LEN_W'(1);
                  if (open_rem_ff == frb_pkg::LEN_W'(1)) begin
                     wp_in       = wrap((AW + 1)'(wp_ff) + (AW + 1)'(open_span));
                     used_in     = used_ff + CW'(open_span);
                     open_tot_in = '0;
                  end
               end
            end else if (open_rem_ff != '0 || mode_ff > frb_pkg::MODE_TAKE) begin
               // A frame is open, or the mode is unknown.
               state_in      = frb_pkg::S_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = frb_pkg::STAT_BUSY;
            end else if (mode_ff == frb_pkg::MODE_BEGIN) begin
               if (bad_len) begin
                  state_in      = frb_pkg::S_IDLE;
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = frb_pkg::STAT_BAD_LEN;
               end else begin
                  state_in = frb_pkg::S_FIT;
               end
            end else if (mode_ff == frb_pkg::MODE_TAKE) begin
               state_in     = frb_pkg::S_IDLE;
               rsp_valid_in = 1'b1;
               rsp_drop_in  = drop_ff;
               drop_in      = '0;
            end else begin
               // Read or pop: fetch the head prefix unless the queue is empty.
               if (used_short) begin
                  state_in      = frb_pkg::S_IDLE;
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = frb_pkg::STAT_EMPTY;
               end else begin
                  mem_raddr = rp_ff;
                  state_in  = frb_pkg::S_PFX_LO;
               end
            end
         end

         frb_pkg::S_FIT: begin
            // Drop oldest frames one at a time until the new frame fits.
            priority if (fits) begin
               mem_we    = 1'b1;
               mem_waddr = wp_ff;
               mem_wdata = flen_ff[frb_pkg::BYTE_W-1:0];
               state_in  = frb_pkg::S_PFX_WR;
            end else if (used_short) begin
               rp_in   = wp_ff;
               used_in = '0;
               drop_in = drop_ff + frb_pkg::DROP_W'(1);
            end else begin
               mem_raddr = rp_ff;
               state_in  = frb_pkg::S_PFX_LO;
            end
         end

         frb_pkg::S_PFX_WR: begin
            mem_we      = 1'b1;
            mem_waddr   = wrap((AW + 1)'(wp_ff) + (AW + 1)'(1));
            mem_wdata   = frb_pkg::BYTE_W'(flen_ff >> frb_pkg::BYTE_W);
            open_tot_in = flen_ff;
            open_rem_in = flen_ff;
            state_in    = frb_pkg::S_IDLE;
            rsp_valid_in = 1'b1;
         end

         frb_pkg::S_PFX_LO: begin
            pfx_lo_in = mem_rdata;
            mem_raddr = wrap((AW + 1)'(rp_ff) + (AW + 1)'(1));
            state_in  = frb_pkg::S_PFX_HI;
         end

         frb_pkg::S_PFX_HI: begin
            priority if (mode_ff == frb_pkg::MODE_BEGIN) begin
               // An inconsistent prefix empties the whole queue.
               if (head_ok) begin
                  rp_in   = wrap((AW + 1)'(rp_ff) + (AW + 1)'(head_tot));
                  used_in = used_ff - CW'(head_tot);
               end else begin
                  rp_in   = wp_ff;
                  used_in = '0;
               end
               drop_in  = drop_ff + frb_pkg::DROP_W'(1);
               state_in = frb_pkg::S_FIT;
            end else if (mode_ff == frb_pkg::MODE_POP) begin
               state_in     = frb_pkg::S_IDLE;
               rsp_valid_in = 1'b1;
               if (head_ok) begin
                  rp_in   = wrap((AW + 1)'(rp_ff) + (AW + 1)'(head_tot));
                  used_in = used_ff - CW'(head_tot);
               end else begin
                  rsp_status_in = frb_pkg::STAT_EMPTY;
               end
            end else begin
               if (!head_ok || head_pfx > sat_limit) begin
                  state_in      = frb_pkg::S_IDLE;
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = frb_pkg::STAT_EMPTY;
               end else if (frb_pkg::PFX_W'(offset_ff) < head_pfx) begin
                  // The offset lies inside a committed frame, so the address
                  // stays within one ring length of the read pointer.
                  hlen_in   = frb_pkg::LEN_W'(head_pfx);
                  mem_raddr = wrap((AW + 1)'(rp_ff)
                                 + (AW + 1)'(frb_pkg::PREFIX_BYTES)
                                 + (AW + 1)'(offset_ff));
                  state_in  = frb_pkg::S_DATA;
               end else begin
                  state_in        = frb_pkg::S_IDLE;
                  rsp_valid_in    = 1'b1;
                  rsp_head_len_in = frb_pkg::LEN_W'(head_pfx);
               end
            end
         end

         frb_pkg::S_DATA: begin
            state_in         = frb_pkg::S_IDLE;
            rsp_valid_in     = 1'b1;
            rsp_head_len_in  = hlen_ff;
            rsp_read_byte_in = mem_rdata;
         end

         default: begin
            state_in = frb_pkg::S_IDLE;
         end
      endcase

      // Every beat reports the used bytes after the request took effect.
      rsp_used_in = frb_pkg::USED_W'(used_in);
   end

   assign busy           = state_ff != frb_pkg::S_IDLE;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_head_len   = rsp_head_len_ff;
   assign rsp_read_byte  = rsp_read_byte_ff;
   assign rsp_drop_total = rsp_drop_ff;
   assign rsp_used_bytes = rsp_used_ff;

endmodule

[hdl/frb_ram.sv]
// ----------------------------------------------------------------------------
// frb_ram
// Byte-wide ring storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module frb_ram #(
   parameter int DEPTH = frb_pkg::DEF_BUFFER_BYTES,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [AW-1:0]               wr_addr,
   input  logic [frb_pkg::BYTE_W-1:0]  wr_data,
   input  logic [AW-1:0]               rd_addr,
   output logic [frb_pkg::BYTE_W-1:0]  rd_data
);

   logic [frb_pkg::BYTE_W-1:0] mem_ff [DEPTH];
   logic [frb_pkg::BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb - frame ring buffer with drop-oldest overflow
// Drives begin-push, push-byte, read, pop and drop-count beats into the ring,
// keeps its own shadow of the ring, its pointers, the open frame and the drop
// counter, and checks every response beat field by field in order of issue.
// Directed tests cover the empty queue, bad lengths, rejection while a frame
// is open, one-byte and longest frames; a long random run with fill-heavy and
// drain-heavy phases forces wrap-around and the dropping of old frames.
// ----------------------------------------------------------------------------
module tb;

   // The block is built with its default sizes; the shadow ring matches them.
   localparam int RING_BYTES  = frb_pkg::DEF_BUFFER_BYTES;
   localparam int RAW         = $clog2(RING_BYTES);
   localparam int MAX_LEN     = frb_pkg::DEF_MAX_FRAME;
   localparam int LEN_MAX     = (1 << frb_pkg::LEN_W) - 1;
   localparam int BYTE_MAX    = (1 << frb_pkg::BYTE_W) - 1;
   localparam int MODE_MAX    = (1 << frb_pkg::MODE_W) - 1;
   localparam int ITEM_TARGET = 1950;
   localparam int CYCLE_LIMIT = 400000;
   localparam int GAP_MAX     = 11;
   localparam int TAIL_CYCLES = 16;

   // One expected response beat, tagged with the request it belongs to.
   typedef struct {
      int unsigned                 seq;
      logic [frb_pkg::STAT_W-1:0]  status;
      logic [frb_pkg::LEN_W-1:0]   head_len;
      logic [frb_pkg::BYTE_W-1:0]  read_byte;
      logic [frb_pkg::DROP_W-1:0]  drop_total;
      logic [frb_pkg::USED_W-1:0]  used_bytes;
   } ring_result_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        start = 1'b0;
   logic                        busy;
   logic [frb_pkg::MODE_W-1:0]  req_mode = '0;
   logic [frb_pkg::LEN_W-1:0]   req_frame_len = '0;
   logic [frb_pkg::BYTE_W-1:0]  req_data_byte = '0;
   logic [frb_pkg::LEN_W-1:0]   req_read_limit = '0;
   logic [frb_pkg::BYTE_W-1:0]  req_byte_offset = '0;
   logic                        rsp_valid;
   logic [frb_pkg::STAT_W-1:0]  rsp_status;
   logic [frb_pkg::LEN_W-1:0]   rsp_head_len;
   logic [frb_pkg::BYTE_W-1:0]  rsp_read_byte;
   logic [frb_pkg::DROP_W-1:0]  rsp_drop_total;
   logic [frb_pkg::USED_W-1:0]  rsp_used_bytes;

   frame_ring_buffer_drop_oldest uut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_mode        (req_mode),
      .req_frame_len   (req_frame_len),
      .req_data_byte   (req_data_byte),
      .req_read_limit  (req_read_limit),
      .req_byte_offset (req_byte_offset),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_head_len    (rsp_head_len),
      .rsp_read_byte   (rsp_read_byte),
      .rsp_drop_total  (rsp_drop_total),
      .rsp_used_bytes  (rsp_used_bytes)
   );

   always #1 clock = ~clock;

   // ------------------------------------------------------------------------
   // Shadow of the block. The ring contents, both pointers, the committed
   // byte count, the open frame and the drop counter are tracked here and
   // advanced once for every request beat the block accepts.
   // ------------------------------------------------------------------------
   logic [frb_pkg::BYTE_W-1:0]  shadow_ring [RING_BYTES];
   logic [RAW-1:0]              wr_pos = '0;
   logic [RAW-1:0]              rd_pos = '0;
   int unsigned                 used_cnt = 0;
   int unsigned                 open_left = 0;
   int unsigned                 open_len = 0;
   logic [frb_pkg::DROP_W-1:0]  drop_cnt = '0;

   // Responses still owed by the block, oldest first.
   ring_result_type     owed_results[$];

   int unsigned         items_sent = 0;
   int unsigned         errors = 0;
   int unsigned         cycles = 0;
   // When set, the sender issues beats back to back with no idle cycles.
   bit                  burst = 1'b0;

   initial begin
      foreach (shadow_ring[i]) shadow_ring[i] = '0;
   end

   function automatic logic [RAW-1:0] wrap_addr(logic [RAW-1:0] base, int unsigned off);
      return RAW'((32'(base) + off) % RING_BYTES);
   endfunction

   // Length written in the prefix of the frame at the read pointer.
   function automatic int unsigned head_prefix();
      return 32'({shadow_ring[wrap_addr(rd_pos, 1)], shadow_ring[rd_pos]});
   endfunction

   // A head frame exists only if its prefix fits inside the committed bytes.
   function automatic bit head_present();
      return used_cnt >= frb_pkg::PREFIX_BYTES
          && frb_pkg::PREFIX_BYTES + head_prefix() <= used_cnt;
   endfunction

   // Discard the oldest frame to make room; a prefix that claims more bytes
   // than are committed empties the whole queue. Every call counts one drop.
   function automatic void evict_head();
      int unsigned total;
      if (head_present()) begin
         total = frb_pkg::PREFIX_BYTES + head_prefix();
         rd_pos = wrap_addr(rd_pos, total);
         used_cnt -= total;
      end else begin
         rd_pos = wr_pos;
         used_cnt = 0;
      end
      drop_cnt++;
   endfunction

   // Works out the response to one accepted request and advances the shadow.
   function automatic ring_result_type ring_predict(
      logic [frb_pkg::MODE_W-1:0] mode, logic [frb_pkg::LEN_W-1:0] flen,
      logic [frb_pkg::BYTE_W-1:0] dbyte, logic [frb_pkg::LEN_W-1:0] limit,
      logic [frb_pkg::BYTE_W-1:0] offset);
      ring_result_type r;
      int unsigned     total;
      int unsigned     lim;
      int unsigned     pos;
      r = '{default: '0};
      r.status = frb_pkg::STAT_OK;
      if (mode == frb_pkg::MODE_PUSH) begin
         if (open_left == 0) begin
            r.status = frb_pkg::STAT_BUSY;
         end else begin
            pos = frb_pkg::PREFIX_BYTES + open_len - open_left;
            shadow_ring[wrap_addr(wr_pos, pos)] = dbyte;
            open_left--;
            // The last byte commits the frame together with its prefix.
            if (open_left == 0) begin
               total = frb_pkg::PREFIX_BYTES + open_len;
               wr_pos = wrap_addr(wr_pos, total);
               used_cnt += total;
               open_len = 0;
            end
         end
      end else if (open_left != 0 || mode > frb_pkg::MODE_TAKE) begin
         r.status = frb_pkg::STAT_BUSY;
      end else if (mode == frb_pkg::MODE_BEGIN) begin
         total = frb_pkg::PREFIX_BYTES + 32'(flen);
         if (flen == 0 || flen > MAX_LEN || total > RING_BYTES) begin
            r.status = frb_pkg::STAT_BAD_LEN;
         end else begin
            while (used_cnt + total > RING_BYTES) evict_head();
            shadow_ring[wrap_addr(wr_pos, 0)] = flen[7:0];
            shadow_ring[wrap_addr(wr_pos, 1)] = {7'd0, flen[8]};
            open_len = 32'(flen);
            open_left = 32'(flen);
         end
      end else if (mode == frb_pkg::MODE_READ) begin
         lim = (limit > MAX_LEN) ? MAX_LEN : 32'(limit);
         if (!head_present() || head_prefix() > lim) begin
            r.status = frb_pkg::STAT_EMPTY;
         end else begin
            r.head_len = frb_pkg::LEN_W'(head_prefix());
            if (offset < r.head_len)
               r.read_byte = shadow_ring[wrap_addr(rd_pos,
                                                   frb_pkg::PREFIX_BYTES + 32'(offset))];
         end
      end else if (mode == frb_pkg::MODE_POP) begin
         if (!head_present()) begin
            r.status = frb_pkg::STAT_EMPTY;
         end else begin
            total = frb_pkg::PREFIX_BYTES + head_prefix();
            rd_pos = wrap_addr(rd_pos, total);
            used_cnt -= total;
         end
      end else begin
         r.drop_total = drop_cnt;
         drop_cnt = '0;
      end
      r.used_bytes = frb_pkg::USED_W'(used_cnt);
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Request side. Inputs change on the falling edge; a beat is taken on the
   // rising edge that sees start high and busy low. Start stays high between
   // back-to-back beats and drops only for an idle gap.
   // ------------------------------------------------------------------------
   task automatic send_item(logic [frb_pkg::MODE_W-1:0] mode,
                            logic [frb_pkg::LEN_W-1:0] flen,
                            logic [frb_pkg::BYTE_W-1:0] dbyte,
                            logic [frb_pkg::LEN_W-1:0] limit,
                            logic [frb_pkg::BYTE_W-1:0] offset);
      int unsigned gap;
      gap = burst ? 0 : $urandom_range(0, GAP_MAX);
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      start = 1'b1;
      req_mode = mode;
      req_frame_len = flen;
      req_data_byte = dbyte;
      req_read_limit = limit;
      req_byte_offset = offset;
      do @(posedge clock); while (busy);
      owed_results.push_back(ring_predict(mode, flen, dbyte, limit, offset));
      owed_results[$].seq = items_sent;
      items_sent++;
      @(negedge clock);
   endtask

   // Fields a mode does not use are filled with random values throughout.
   function automatic logic [frb_pkg::LEN_W-1:0] any_len();
      return frb_pkg::LEN_W'($urandom_range(0, LEN_MAX));
   endfunction

   function automatic logic [frb_pkg::BYTE_W-1:0] any_byte();
      return frb_pkg::BYTE_W'($urandom_range(0, BYTE_MAX));
   endfunction

   task automatic begin_frame(int unsigned len);
      send_item(frb_pkg::MODE_BEGIN, frb_pkg::LEN_W'(len), any_byte(), any_len(),
                any_byte());
   endtask

   task automatic push_byte(int unsigned value);
      send_item(frb_pkg::MODE_PUSH, any_len(), frb_pkg::BYTE_W'(value), any_len(),
                any_byte());
   endtask

   task automatic read_head(int unsigned limit, int unsigned offset);
      send_item(frb_pkg::MODE_READ, any_len(), any_byte(), frb_pkg::LEN_W'(limit),
                frb_pkg::BYTE_W'(offset));
   endtask

   task automatic other_mode(logic [frb_pkg::MODE_W-1:0] mode);
      send_item(mode, any_len(), any_byte(), any_len(), any_byte());
   endtask

   // Anything but a push byte; while a frame is open these must all bounce.
   task automatic stray_item();
      int unsigned pick;
      pick = $urandom_range(0, 4);
      case (pick)
         0: begin_frame($urandom_range(0, LEN_MAX));
         1: read_head(32'(any_len()), 32'(any_byte()));
         2: other_mode(frb_pkg::MODE_POP);
         3: other_mode(frb_pkg::MODE_TAKE);
         default: other_mode(frb_pkg::MODE_W'($urandom_range(frb_pkg::MODE_TAKE + 1,
                                                            MODE_MAX)));
      endcase
   endtask

   // A complete frame: begin push, then its bytes, with stray beats mixed in
   // at the given rate (percent) to check that an open frame rejects them.
   task automatic push_frame(int unsigned len, int unsigned noise_pct);
      begin_frame(len);
      repeat (len) begin
         if ($urandom_range(0, 99) < noise_pct) stray_item();
         push_byte(32'(any_byte()));
      end
   endtask

   // Stop sending until every outstanding response has come back.
   task automatic drain();
      start = 1'b0;
      while (owed_results.size() != 0) @(negedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Response side. Every strobed beat is matched against the oldest owed
   // response; the block cannot be stalled, so each beat is taken as shown.
   // ------------------------------------------------------------------------
   task automatic report_mismatch(string what, int unsigned seq,
                                  logic [frb_pkg::DROP_W-1:0] got,
                                  logic [frb_pkg::DROP_W-1:0] want);
      $display("ERROR beat %0d %s: got 0x%0h, expected 0x%0h", seq, what, got, want);
      errors++;
   endtask

   always @(posedge clock) begin
      ring_result_type want;
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("** frame_ring_buffer_drop_oldest: FAILED **");
         $finish;
      end else if (!reset && rsp_valid) begin
         if (owed_results.size() == 0) begin
            report_mismatch("response with nothing owed", items_sent,
                            32'(rsp_status), '0);
         end else begin
            want = owed_results.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", want.seq, 32'(rsp_status), 32'(want.status));
            if (rsp_head_len !== want.head_len)
               report_mismatch("head_len", want.seq, 32'(rsp_head_len),
                               32'(want.head_len));
            if (rsp_read_byte !== want.read_byte)
               report_mismatch("read_byte", want.seq, 32'(rsp_read_byte),
                               32'(want.read_byte));
            if (rsp_drop_total !== want.drop_total)
               report_mismatch("drop_total", want.seq, rsp_drop_total, want.drop_total);
            if (rsp_used_bytes !== want.used_bytes)
               report_mismatch("used_bytes", want.seq, 32'(rsp_used_bytes),
                               32'(want.used_bytes));
         end
      end
   end

   // ------------------------------------------------------------------------
   // Tests.
   // ------------------------------------------------------------------------

   // Fresh queue: reads and pops find nothing, the drop count is zero, a push
   // byte with no open frame bounces, and the unused mode codes bounce too.
   task automatic test_empty_queue();
      read_head(0, 0);
      read_head(LEN_MAX, BYTE_MAX);
      other_mode(frb_pkg::MODE_POP);
      other_mode(frb_pkg::MODE_TAKE);
      push_byte(BYTE_MAX);
      for (int m = frb_pkg::MODE_TAKE + 1; m <= MODE_MAX; m++)
         other_mode(frb_pkg::MODE_W'(m));
   endtask

   // Zero length, one past the longest frame, and the top of the field.
   task automatic test_bad_lengths();
      begin_frame(0);
      begin_frame(MAX_LEN + 1);
      begin_frame(LEN_MAX);
   endtask

   // A one-byte frame: too long for a zero limit, readable at offset zero,
   // an offset past its end reads zero, and a large limit saturates.
   task automatic test_single_byte_frame();
      begin_frame(1);
      push_byte(BYTE_MAX);
      read_head(0, 0);
      read_head(1, 0);
      read_head(LEN_MAX, BYTE_MAX);
      other_mode(frb_pkg::MODE_POP);
      other_mode(frb_pkg::MODE_POP);
      other_mode(frb_pkg::MODE_TAKE);
   endtask

   // While a frame is open, everything except its bytes is turned away.
   task automatic test_open_frame_rejects();
      begin_frame(3);
      read_head(LEN_MAX, 0);
      other_mode(frb_pkg::MODE_POP);
      other_mode(frb_pkg::MODE_TAKE);
      begin_frame(5);
      other_mode(frb_pkg::MODE_W'(MODE_MAX));
      push_byte(0);
      push_byte(8'h5a);
      push_byte(BYTE_MAX);
      read_head(3, 2);
      other_mode(frb_pkg::MODE_POP);
   endtask

   // The longest frame: its last byte sits at the highest offset the field
   // can name, and a limit one short of its length refuses it.
   task automatic test_longest_frame();
      push_frame(MAX_LEN, 0);
      read_head(MAX_LEN, BYTE_MAX);
      read_head(MAX_LEN - 1, 0);
      read_head(LEN_MAX, $urandom_range(0, BYTE_MAX));
      other_mode(frb_pkg::MODE_POP);
   endtask

   // Mostly small frames so the ring fills and wraps often; now and then a
   // large one, and rarely the longest.
   function automatic int unsigned draw_frame_len();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 75) return $urandom_range(1, 8);
      else if (pick < 93) return $urandom_range(9, 48);
      else if (pick < 99) return $urandom_range(49, MAX_LEN - 1);
      else return MAX_LEN;
   endfunction

   // Random traffic in phases: fill-heavy phases push far more than they pop,
   // so begin push has to drop old frames; drain-heavy phases turn most pushes
   // into pops, empty the ring and hit the empty cases. Reads mostly target
   // real bytes of the head.
   task automatic test_random_traffic();
      bit          filling;
      int unsigned pick;
      int unsigned hl;
      int unsigned next_pause;
      filling = 1'b1;
      next_pause = items_sent + 150;
      while (items_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 29) == 0) filling = ~filling;
         if ($urandom_range(0, 15) == 0) burst = ~burst;
         if (items_sent >= next_pause) begin
            drain();
            next_pause = items_sent + $urandom_range(100, 300);
         end
         pick = $urandom_range(0, 99);
         if (!filling) pick = (pick < 50) ? 70 + pick / 5 : pick;
         hl = (used_cnt >= frb_pkg::PREFIX_BYTES) ? head_prefix() : 0;
         if (pick < 55) begin
            push_frame(draw_frame_len(), 4);
         end else if (pick < 70) begin
            read_head(($urandom_range(0, 9) < 7) ? $urandom_range(hl, LEN_MAX)
                                                 : 32'(any_len()),
                      (hl > 0 && $urandom_range(0, 9) < 8) ? $urandom_range(0, hl - 1)
                                                           : 32'(any_byte()));
         end else if (pick < 80) begin
            other_mode(frb_pkg::MODE_POP);
         end else if (pick < 85) begin
            other_mode(frb_pkg::MODE_TAKE);
         end else if (pick < 90) begin
            begin_frame(($urandom_range(0, 3) == 0) ? 0
                                                    : $urandom_range(MAX_LEN + 1, LEN_MAX));
         end else if (pick < 95) begin
            push_byte(32'(any_byte()));
         end else begin
            other_mode(frb_pkg::MODE_W'($urandom_range(frb_pkg::MODE_TAKE + 1, MODE_MAX)));
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_queue();
      test_bad_lengths();
      test_single_byte_frame();
      test_open_frame_rejects();
      drain();
      test_longest_frame();
      test_random_traffic();

      // All requests are in; wait for the last responses plus a short tail
      // so that a stray extra beat from the block is caught as well.
      drain();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (errors == 0) begin
         $display("** frame_ring_buffer_drop_oldest: PASSED **");
      end else begin
         $display("** frame_ring_buffer_drop_oldest: FAILED **");
      end
      $finish;
   end

endmodule
